// ===== rtl/v4tup_pkg.sv =====
// Package for the IPv4 five-tuple parser: frame offsets, protocol constants,
// status codes and the structs passed between the capture and check logic.
// No dependencies.
`default_nettype none

package v4tup_pkg;

  // Byte positions and limits within the frame
  localparam int unsigned COUNT_W = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 7'd127;
  localparam logic [COUNT_W-1:0] ETH_HDR_BYTES  = 7'd14;
  localparam logic [COUNT_W-1:0] IP_HDR_END     = 7'd34;
  localparam logic [COUNT_W-1:0] POS_TYPE_HI    = 7'd12;
  localparam logic [COUNT_W-1:0] POS_TYPE_LO    = 7'd13;
  localparam logic [COUNT_W-1:0] POS_IHL        = 7'd14;
  localparam logic [COUNT_W-1:0] POS_FRAG_HI    = 7'd20;
  localparam logic [COUNT_W-1:0] POS_FRAG_LO    = 7'd21;
  localparam logic [COUNT_W-1:0] POS_PROTO      = 7'd23;
  localparam logic [COUNT_W-1:0] POS_SRC_FIRST  = 7'd26;
  localparam logic [COUNT_W-1:0] POS_SRC_LAST   = 7'd29;
  localparam logic [COUNT_W-1:0] POS_DST_FIRST  = 7'd30;
  localparam logic [COUNT_W-1:0] POS_DST_LAST   = 7'd33;
  localparam logic [COUNT_W-1:0] PORT_BYTES     = 7'd4;

  // Protocol constants
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IHL_MIN        = 4'd5;
  localparam logic [13:0] FRAG_MASK      = 14'h3FFF;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_TRUNC = 2'd1,
    STATUS_UNSUP = 2'd2
  } status_t;

  // Captured header fields, including the byte now being taken
  typedef struct packed {
    logic [COUNT_W-1:0] byte_count;
    logic [15:0]        eth_type;
    logic [3:0]         header_words;
    logic [13:0]        fragment_field;
    logic [7:0]         protocol;
    logic [31:0]        src_ip;
    logic [31:0]        dst_ip;
    logic [31:0]        ports;
  } flow_fields_t;

  // One parse result
  typedef struct packed {
    status_t     status;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  protocol;
  } tuple_t;

endpackage

`default_nettype wire

// ===== rtl/v4tup_if.sv =====
// Valid/ready channel interfaces for the frame byte stream and the results.
// Depends on nothing.
`default_nettype none

interface v4tup_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface v4tup_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [7:0]  protocol;

  modport source (output valid, output status, output source_address,
                  output dest_address, output source_port, output dest_port,
                  output protocol, input ready);
  modport sink   (input valid, input status, input source_address,
                  input dest_address, input source_port, input dest_port,
                  input protocol, output ready);
endinterface

`default_nettype wire

// ===== rtl/v4tup_capture.sv =====
// Header field capture: byte counter and the registers that pick the
// ethertype, IHL, fragment field, protocol, addresses and ports. Uses v4tup_pkg.
`default_nettype none

module v4tup_capture import v4tup_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire logic [7:0]   frame_byte,
  input  wire logic         last_byte,
  output flow_fields_t      fields
);

  flow_fields_t state;
  flow_fields_t state_next;

  logic [COUNT_W-1:0] pos;
  logic [3:0]         ihl_now;
  logic [COUNT_W-1:0] port_start;
  logic [COUNT_W-1:0] port_offset;

  assign pos = state.byte_count;

  // IHL in effect for this byte, including the one now being taken
  assign ihl_now = (pos == POS_IHL) ? frame_byte[3:0] : state.header_words;

  // Start of the ports: 14 + 4 * IHL, at most 74
  assign port_start  = ETH_HDR_BYTES + {1'b0, ihl_now, 2'b00};
  assign port_offset = pos - port_start;

  // Fold the current byte into the captured fields
  always_comb begin
    state_next = state;
    if (pos < COUNT_MAX) begin
      state_next.byte_count = pos + 7'd1;
      if (pos == POS_TYPE_HI || pos == POS_TYPE_LO) begin
        state_next.eth_type = {state.eth_type[7:0], frame_byte};
      end else if (pos == POS_IHL) begin
        state_next.header_words = frame_byte[3:0];
      end else if (pos == POS_FRAG_HI) begin
        state_next.fragment_field = {frame_byte[5:0], state.fragment_field[7:0]};
      end else if (pos == POS_FRAG_LO) begin
        state_next.fragment_field = {state.fragment_field[13:8], frame_byte};
      end else if (pos == POS_PROTO) begin
        state_next.protocol = frame_byte;
      end else if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) begin
        state_next.src_ip = {state.src_ip[23:0], frame_byte};
      end else if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) begin
        state_next.dst_ip = {state.dst_ip[23:0], frame_byte};
      end
      if (ihl_now >= IHL_MIN && pos >= port_start &&
          port_offset < PORT_BYTES) begin
        state_next.ports = {state.ports[23:0], frame_byte};
      end
    end
  end

  // Advance on each byte, clear after the final byte of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step) begin
      if (last_byte) begin
        state <= '0;
      end else begin
        state <= state_next;
      end
    end
  end

  assign fields = state_next;

endmodule

`default_nettype wire

// ===== rtl/v4tup_judge.sv =====
// Frame checks in priority order and masking of the tuple on a bad status.
// Uses v4tup_pkg.
`default_nettype none

module v4tup_judge import v4tup_pkg::*; (
  input  wire flow_fields_t fields,
  output tuple_t            tuple
);

  logic [COUNT_W-1:0] ports_end;
  status_t            status;

  // End of the port words: 14 + 4 * IHL + 4, at most 78
  assign ports_end = ETH_HDR_BYTES + {1'b0, fields.header_words, 2'b00} + PORT_BYTES;

  // Pick the first failing check
  always_comb begin
    if (fields.byte_count < ETH_HDR_BYTES) begin
      status = STATUS_TRUNC;
    end else if (fields.eth_type != ETHERTYPE_IPV4) begin
      status = STATUS_UNSUP;
    end else if (fields.byte_count < IP_HDR_END) begin
      status = STATUS_TRUNC;
    end else if (fields.header_words < IHL_MIN) begin
      status = STATUS_TRUNC;
    end else if ((fields.fragment_field & FRAG_MASK) != 14'd0) begin
      status = STATUS_UNSUP;
    end else if (fields.protocol != PROTO_TCP && fields.protocol != PROTO_UDP) begin
      status = STATUS_UNSUP;
    end else if (fields.byte_count < ports_end) begin
      status = STATUS_TRUNC;
    end else begin
      status = STATUS_OK;
    end
  end

  // Zero the tuple unless the frame passed
  always_comb begin
    tuple        = '0;
    tuple.status = status;
    if (status == STATUS_OK) begin
      tuple.source_address = fields.src_ip;
      tuple.dest_address   = fields.dst_ip;
      tuple.source_port    = fields.ports[31:16];
      tuple.dest_port      = fields.ports[15:0];
      tuple.protocol       = fields.protocol;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ipv4_five_tuple_parser.sv =====
// The final byte goes through the input register before the result register loads.
// Throughput: one frame byte per cycle; the input stage stalls only while a
// final byte waits behind a result that has not been taken.
// Reset: synchronous rst empties the input and result registers and clears
// all captured header fields. Depends on v4tup_pkg, v4tup_if, v4tup_capture, v4tup_judge.
`default_nettype none

module ipv4_five_tuple_parser import v4tup_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  v4tup_frame_if.sink    frame,
  v4tup_result_if.source result
);

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_last;
  logic         advance;
  logic         out_valid;
  tuple_t       out_tuple;
  flow_fields_t fields;
  tuple_t       tuple;

  // Hold a final byte only while the result register is full and stalled
  assign advance     = in_valid && (!in_last || !out_valid || result.ready);
  assign frame.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (frame.ready) begin
      in_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      in_byte <= frame.frame_byte;
      in_last <= frame.last_byte;
    end
  end

  v4tup_capture u_capture (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .frame_byte (in_byte),
    .last_byte  (in_last),
    .fields     (fields)
  );

  v4tup_judge u_judge (
    .fields (fields),
    .tuple  (tuple)
  );

  // Result register: load on a final byte, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_tuple <= tuple;
    end
  end

  assign result.valid          = out_valid;
  assign result.status         = out_tuple.status;
  assign result.source_address = out_tuple.source_address;
  assign result.dest_address   = out_tuple.dest_address;
  assign result.source_port    = out_tuple.source_port;
  assign result.dest_port      = out_tuple.dest_port;
  assign result.protocol       = out_tuple.protocol;

endmodule

`default_nettype wire

// ===== rtl/v4tup_checker.sv =====
// Port-level checks for ipv4_five_tuple_parser and the bind that attaches them.
// Uses v4tup_pkg.
`default_nettype none

module v4tup_checker import v4tup_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_last,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [31:0] source_address,
  input wire logic [31:0] dest_address,
  input wire logic [15:0] source_port,
  input wire logic [15:0] dest_port,
  input wire logic [7:0]  protocol
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(status) && $stable(source_address) &&
      $stable(dest_address) && $stable(source_port) && $stable(dest_port) &&
      $stable(protocol))
    else $error("result payload changed while stalled");

  // A new result follows a final byte transfer through the input register
  a_result_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("result without a final byte");

  // A failed frame shows an all-zero tuple
  a_zero_tuple: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> source_address == 32'd0 &&
      dest_address == 32'd0 && source_port == 16'd0 && dest_port == 16'd0 &&
      protocol == 8'd0)
    else $error("tuple not cleared on failed frame");

  // A passing frame carries TCP or UDP
  a_ok_proto: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OK |-> protocol == PROTO_TCP || protocol == PROTO_UDP)
    else $error("ok result with unexpected protocol");

endmodule

bind ipv4_five_tuple_parser v4tup_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (frame.valid),
  .in_ready       (frame.ready),
  .in_last        (frame.last_byte),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .status         (result.status),
  .source_address (result.source_address),
  .dest_address   (result.dest_address),
  .source_port    (result.source_port),
  .dest_port      (result.dest_port),
  .protocol       (result.protocol)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for ipv4_five_tuple_parser: Ethernet/IPv4 frames go in one byte per transfer
// and each frame's 5-tuple result is checked against a byte-level parse tracker.
// Depends on v4tup_pkg, v4tup_if and the parser RTL.

module tb_top;
  import v4tup_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 300;
  localparam int RAND_BYTES   = 150;
  localparam int N_DIRECTED   = 16;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  // One directed frame: header fields, filler and, for error frames, the status typed in
  typedef struct packed {
    logic [7:0]  len;
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [15:0] frag;
    logic [7:0]  proto;
    fill_t       fill;
    logic        typed;
    status_t     status;
  } frame_case_t;

  localparam frame_case_t DIRECTED_FRAMES [N_DIRECTED] = '{
    // single byte, short frame, foreign ethertypes
    '{8'd1,   16'h0800, 4'd5,  16'h0000, PROTO_TCP, FILL_RANDOM, 1'b1, STATUS_TRUNC},
    '{8'd13,  16'h0800, 4'd5,  16'h0000, PROTO_TCP, FILL_RANDOM, 1'b1, STATUS_TRUNC},
    '{8'd14,  16'h86DD, 4'd5,  16'h0000, PROTO_TCP, FILL_RANDOM, 1'b1, STATUS_UNSUP},
    '{8'd14,  16'hFFFF, 4'd5,  16'h0000, PROTO_UDP, FILL_ONES,   1'b1, STATUS_UNSUP},
    // short IP header, missing ports, minimal good frame
    '{8'd33,  16'h0800, 4'd5,  16'h0000, PROTO_TCP, FILL_RANDOM, 1'b1, STATUS_TRUNC},
    '{8'd37,  16'h0800, 4'd5,  16'h0000, PROTO_UDP, FILL_RANDOM, 1'b1, STATUS_TRUNC},
    '{8'd38,  16'h0800, 4'd5,  16'h0000, PROTO_TCP, FILL_RANDOM, 1'b0, STATUS_OK},
    // small IHL
    '{8'd34,  16'h0800, 4'd4,  16'h0000, PROTO_TCP, FILL_RANDOM, 1'b1, STATUS_TRUNC},
    // fragments: MF, largest offset, DF and reserved bit alone
    '{8'd34,  16'h0800, 4'd5,  16'h2000, PROTO_TCP, FILL_RANDOM, 1'b1, STATUS_UNSUP},
    '{8'd34,  16'h0800, 4'd5,  16'h1FFF, PROTO_UDP, FILL_RANDOM, 1'b1, STATUS_UNSUP},
    '{8'd38,  16'h0800, 4'd5,  16'hC000, PROTO_UDP, FILL_RANDOM, 1'b0, STATUS_OK},
    // other protocols
    '{8'd34,  16'h0800, 4'd5,  16'h0000, 8'd0,      FILL_RANDOM, 1'b1, STATUS_UNSUP},
    '{8'd34,  16'h0800, 4'd5,  16'h0000, 8'd255,    FILL_RANDOM, 1'b1, STATUS_UNSUP},
    // largest IHL, exact length
    '{8'd78,  16'h0800, 4'd15, 16'h0000, PROTO_UDP, FILL_RANDOM, 1'b0, STATUS_OK},
    // long frame past the count saturation, all-ones and all-zero content
    '{8'd128, 16'h0800, 4'd5,  16'h0000, PROTO_TCP, FILL_ONES,   1'b0, STATUS_OK},
    '{8'd38,  16'h0800, 4'd5,  16'h0000, PROTO_UDP, FILL_ZERO,   1'b0, STATUS_OK}
  };

  logic clk = 1'b0;
  logic rst;

  v4tup_frame_if  frame_ch();
  v4tup_result_if result_ch();

  ipv4_five_tuple_parser dut (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame_ch),
    .result (result_ch)
  );

  always #5 clk = ~clk;

  // Header fields captured so far in the current frame
  logic [6:0]  seen_count = '0;
  logic [15:0] seen_etype = '0;
  logic [3:0]  seen_ihl   = '0;
  logic [13:0] seen_frag  = '0;
  logic [7:0]  seen_proto = '0;
  logic [31:0] seen_src   = '0;
  logic [31:0] seen_dst   = '0;
  logic [31:0] seen_ports = '0;

  tuple_t      expected_tuples[$];
  logic [7:0]  frame_bytes[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          long_hold_req = 1'b0;

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    else if (roll < 93) return $urandom_range(1, 3);
    else return $urandom_range(4, 24);
  endfunction

  // Advance the parse by one accepted byte; on the final byte yield the tuple
  task automatic parse_frame_byte(input logic [7:0] b, input logic l,
                                  output bit done, output tuple_t t);
    int      pos;
    int      pstart;
    int      flen;
    status_t st;
    done = 1'b0;
    t = '0;
    pos = int'(seen_count);
    if (seen_count != COUNT_MAX) begin
      if (pos == POS_TYPE_HI || pos == POS_TYPE_LO) seen_etype = {seen_etype[7:0], b};
      else if (pos == POS_IHL) seen_ihl = b[3:0];
      else if (pos == POS_FRAG_HI) seen_frag[13:8] = b[5:0];
      else if (pos == POS_FRAG_LO) seen_frag[7:0] = b;
      else if (pos == POS_PROTO) seen_proto = b;
      else if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) seen_src = {seen_src[23:0], b};
      else if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) seen_dst = {seen_dst[23:0], b};
      // ports sit right after the variable-length IP header
      if (seen_ihl >= IHL_MIN) begin
        pstart = int'(ETH_HDR_BYTES) + 4 * int'(seen_ihl);
        if (pos >= pstart && pos < pstart + int'(PORT_BYTES))
          seen_ports = {seen_ports[23:0], b};
      end
      seen_count = seen_count + 7'd1;
    end
    if (l) begin
      flen = int'(seen_count);
      if (flen < int'(ETH_HDR_BYTES)) st = STATUS_TRUNC;
      else if (seen_etype != ETHERTYPE_IPV4) st = STATUS_UNSUP;
      else if (flen < int'(IP_HDR_END)) st = STATUS_TRUNC;
      else if (seen_ihl < IHL_MIN) st = STATUS_TRUNC;
      else if ((seen_frag & FRAG_MASK) != '0) st = STATUS_UNSUP;
      else if (seen_proto != PROTO_TCP && seen_proto != PROTO_UDP) st = STATUS_UNSUP;
      else if (flen < int'(ETH_HDR_BYTES) + 4 * int'(seen_ihl) + int'(PORT_BYTES))
        st = STATUS_TRUNC;
      else st = STATUS_OK;
      t.status = st;
      if (st == STATUS_OK) begin
        t.source_address = seen_src;
        t.dest_address   = seen_dst;
        t.source_port    = seen_ports[31:16];
        t.dest_port      = seen_ports[15:0];
        t.protocol       = seen_proto;
      end
      done = 1'b1;
      // start over for the next frame
      seen_count = '0;
      seen_etype = '0;
      seen_ihl   = '0;
      seen_frag  = '0;
      seen_proto = '0;
      seen_src   = '0;
      seen_dst   = '0;
      seen_ports = '0;
    end
  endtask

  // Fill frame_bytes with content, then lay the header fields over it
  task automatic build_frame(input int len, input logic [15:0] etype, input logic [3:0] ihl,
                             input logic [15:0] frag, input logic [7:0] proto,
                             input fill_t fill);
    logic [7:0] b;
    frame_bytes.delete();
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom_range(0, 255));
      endcase
      if (i == POS_TYPE_HI) b = etype[15:8];
      else if (i == POS_TYPE_LO) b = etype[7:0];
      else if (i == POS_IHL) b = {b[7:4], ihl};
      else if (i == POS_FRAG_HI) b = frag[15:8];
      else if (i == POS_FRAG_LO) b = frag[7:0];
      else if (i == POS_PROTO) b = proto;
      frame_bytes.push_back(b);
    end
  endtask

  // Well-formed frames with random content, some broken in one field, a few pure noise
  task automatic make_random_frame();
    int          kind;
    int          flen;
    int          base;
    int          roll;
    logic [15:0] etype;
    logic [15:0] frag;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    kind  = $urandom_range(0, 99);
    ihl   = ($urandom_range(0, 3) != 0) ? IHL_MIN : 4'($urandom_range(6, 15));
    etype = ETHERTYPE_IPV4;
    frag  = {2'($urandom_range(0, 3)), 14'h0};
    proto = ($urandom_range(0, 1) != 0) ? PROTO_TCP : PROTO_UDP;
    base  = int'(ETH_HDR_BYTES) + 4 * int'(ihl) + int'(PORT_BYTES);
    roll  = $urandom_range(0, 9);
    if (roll < 7) flen = base + $urandom_range(0, 16);
    else if (roll < 9) flen = base + $urandom_range(17, 60);
    else flen = $urandom_range(128, 150);
    if (kind >= 90) begin
      build_frame($urandom_range(1, 80), 16'($urandom), 4'($urandom), 16'($urandom),
                  8'($urandom), FILL_RANDOM);
    end else begin
      if (kind >= 65) begin
        case ($urandom_range(0, 5))
          0: etype = 16'($urandom);
          1: ihl = 4'($urandom_range(0, 4));
          2: frag = frag | 16'h2000;
          3: frag = frag | 16'($urandom_range(1, 16'h1FFF));
          4: proto = 8'($urandom);
          default: flen = $urandom_range(1, flen - 1);
        endcase
      end
      build_frame(flen, etype, ihl, frag, proto, FILL_RANDOM);
    end
  endtask

  // Offer one byte, hold it until the transfer, then track it
  task automatic send_byte(input logic [7:0] b, input logic l, input bit steady,
                           input bit has_fixed, input tuple_t fixed);
    int     gap;
    bit     done;
    tuple_t t;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      frame_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    frame_ch.valid      <= 1'b1;
    frame_ch.frame_byte <= b;
    frame_ch.last_byte  <= l;
    @(posedge clk);
    while (!frame_ch.ready) @(posedge clk);
    parse_frame_byte(b, l, done, t);
    if (done) expected_tuples.push_back(has_fixed ? fixed : t);
    @(negedge clk);
  endtask

  task automatic send_frame(input bit has_fixed, input tuple_t fixed);
    bit steady;
    steady = ($urandom_range(0, 3) == 0);
    foreach (frame_bytes[i])
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1, steady, has_fixed, fixed);
  endtask

  // Drop valid and hold until every expected tuple has come back
  task automatic wait_results_drained();
    frame_ch.valid <= 1'b0;
    while (expected_tuples.size() != 0) @(negedge clk);
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: random stalls, calm stretches, and one long hold-off on request
  initial begin : result_sink
    int  stall;
    bit  calm;
    stall = 0;
    calm = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        stall--;
      end else begin
        result_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // Check each result transfer against the oldest expected tuple
  always @(posedge clk) begin
    tuple_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_tuples.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d", $time,
                 result_ch.status);
        mismatch_count++;
      end else begin
        want = expected_tuples.pop_front();
        compare_field("status", 32'(want.status), 32'(result_ch.status));
        compare_field("source_address", want.source_address, result_ch.source_address);
        compare_field("dest_address", want.dest_address, result_ch.dest_address);
        compare_field("source_port", 32'(want.source_port), 32'(result_ch.source_port));
        compare_field("dest_port", 32'(want.dest_port), 32'(result_ch.dest_port));
        compare_field("protocol", 32'(want.protocol), 32'(result_ch.protocol));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    frame_case_t fc;
    tuple_t      fixed;
    int          random_bytes;
    random_bytes = 0;
    rst = 1'b1;
    frame_ch.valid = 1'b0;
    frame_ch.frame_byte = '0;
    frame_ch.last_byte = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frames
    for (int n = 0; n < N_DIRECTED; n++) begin
      fc = DIRECTED_FRAMES[n];
      build_frame(int'(fc.len), fc.etype, fc.ihl, fc.frag, fc.proto, fc.fill);
      fixed = '0;
      fixed.status = fc.status;
      send_frame(fc.typed, fixed);
    end
    wait_results_drained();

    // Hold off the result side while short frames keep coming, so the input stalls
    long_hold_req = 1'b1;
    for (int k = 0; k < 12; k++) begin
      build_frame($urandom_range(1, 3), 16'($urandom), 4'($urandom), 16'($urandom),
                  8'($urandom), FILL_RANDOM);
      send_frame(1'b0, '0);
    end
    wait_results_drained();

    // Random frames
    while (random_bytes < RAND_BYTES) begin
      make_random_frame();
      random_bytes += frame_bytes.size();
      send_frame(1'b0, '0);
    end
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
